[hw/rtl/i2cbm_pkg.sv]
// Package for the I2C master bit engine: payload structs, command and phase
// codes, and the constants shared by the front queue, the engine and the top.
// No dependencies.
`timescale 1ns / 1ps

package i2cbm_pkg;

   localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

   localparam logic [15:0] HALF_PERIOD_RESET = 16'd100;
   localparam logic [7:0]  ACK_TIMEOUT_RESET = 8'd250;

   localparam int unsigned CSR_ADDR_WIDTH = 3;
   localparam logic        CSR_IDX_HALF_PERIOD = 1'b0;
   localparam logic        CSR_IDX_ACK_TIMEOUT = 1'b1;

   localparam logic [2:0]  OPCODE_RESERVED = 3'd7;
   localparam int unsigned BITS_PER_BYTE = 8;

   typedef enum logic [2:0] {
      OP_START = 3'd0,
      OP_STOP  = 3'd1,
      OP_WRITE = 3'd2,
      OP_WAIT  = 3'd3,
      OP_READ  = 3'd4,
      OP_ACK   = 3'd5,
      OP_NACK  = 3'd6
   } op_type;

   typedef enum logic [4:0] {
      PH_IDLE    = 5'd0,
      PH_ST_A    = 5'd1,
      PH_ST_B    = 5'd2,
      PH_ST_C    = 5'd3,
      PH_SP_A    = 5'd4,
      PH_SP_B    = 5'd5,
      PH_SP_C    = 5'd6,
      PH_WA_RISE = 5'd7,
      PH_WA_POLL = 5'd8,
      PH_WA_FALL = 5'd9,
      PH_WR_LOW  = 5'd10,
      PH_WR_HIGH = 5'd11,
      PH_WR_TAIL = 5'd12,
      PH_RD_LOW  = 5'd13,
      PH_RD_HIGH = 5'd14,
      PH_AK_LOW  = 5'd15,
      PH_AK_HIGH = 5'd16
   } phase_type;

   typedef struct packed {
      logic       cmd_valid;
      logic [2:0] opcode;
      logic [7:0] write_data;
      logic       sda_in;
   } req_type;

   typedef struct packed {
      logic       scl_out;
      logic       sda_out;
      logic       sda_drive;
      logic       busy_res;
      logic       done_res;
      logic [7:0] read_data;
      logic       ack_missing;
   } rsp_type;

   // A request after classification: cmd_go is set only for a real command.
   typedef struct packed {
      logic       cmd_go;
      op_type     op;
      logic [7:0] write_data;
      logic       sda_in;
   } tick_type;

   typedef struct packed {
      logic     valid;
      tick_type tick;
   } head_type;

endpackage

[hw/rtl/i2c_bit_level_master.sv]
// I2C master bit engine top level: one request is one tick of the pin sequencer.
// Takes one request per cycle while the queue has room and results are not stalled;
// a request's result passes through the front queue, then the engine's output register.
// Reset is synchronous: queue empty, engine idle with SCL and SDA driven high, half period
// 100 ticks, ack timeout 250 ticks. Depends on i2cbm_pkg, i2cbm_front and i2cbm_engine.
`timescale 1ns / 1ps

module i2c_bit_level_master #(
   parameter int unsigned QUEUE_DEPTH = i2cbm_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  i2cbm_pkg::req_type                     req_payload,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output i2cbm_pkg::rsp_type                     rsp_payload,
   input  logic                                   psel,
   input  logic                                   penable,
   input  logic                                   pwrite,
   input  logic [i2cbm_pkg::CSR_ADDR_WIDTH-1:0]   paddr,
   input  logic [31:0]                            pwdata,
   output logic [31:0]                            prdata,
   output logic                                   pready
);

   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [15:0] half_period_ff;
   logic [7:0]  ack_timeout_ff;
   logic        csr_write;
   logic        csr_index;
   logic        pop;
   logic [CNT_W-1:0] q_count;
   i2cbm_pkg::head_type head;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = paddr[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         half_period_ff <= i2cbm_pkg::HALF_PERIOD_RESET;
         ack_timeout_ff <= i2cbm_pkg::ACK_TIMEOUT_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            i2cbm_pkg::CSR_IDX_HALF_PERIOD: half_period_ff <= pwdata[15:0];
            i2cbm_pkg::CSR_IDX_ACK_TIMEOUT: ack_timeout_ff <= pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         i2cbm_pkg::CSR_IDX_HALF_PERIOD: prdata = {16'd0, half_period_ff};
         default:                        prdata = {24'd0, ack_timeout_ff};
      endcase
   end

   i2cbm_front #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .head       (head),
      .pop        (pop),
      .count      (q_count)
   );

   i2cbm_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .pop        (pop),
      .half_period(half_period_ff),
      .ack_timeout(ack_timeout_ff),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload)
   );

   // A completing command is never reported as still busy.
   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_payload.done_res && rsp_payload.busy_res))
      else $error("done and busy reported together");

   // The queue never takes a request while it is full.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |-> (q_count < CNT_W'(QUEUE_DEPTH)))
      else $error("request accepted into a full queue");

   // A queued request with room at the output always produces a result next cycle.
   a_queue_drains: assert property (@(posedge clock) disable iff (reset)
      ((q_count != '0) && !(rsp_valid && rsp_stall)) |=> rsp_valid)
      else $error("queued request did not reach the output");

endmodule

[hw/rtl/i2cbm_front.sv]
// Front end of the I2C master bit engine: accepts requests, classifies the
// command and holds them in a short queue for the engine.
// Depends on i2cbm_pkg.
`timescale 1ns / 1ps

module i2cbm_front #(
   parameter int unsigned QUEUE_DEPTH = i2cbm_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  i2cbm_pkg::req_type   req_payload,
   output i2cbm_pkg::head_type  head,
   input  logic                 pop,
   output logic [$clog2(QUEUE_DEPTH+1)-1:0] count
);

   localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

   i2cbm_pkg::tick_type entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   i2cbm_pkg::tick_type classified;
   logic push;
   logic take;

   always_comb begin
      classified.cmd_go     = req_payload.cmd_valid &&
                              (req_payload.opcode != i2cbm_pkg::OPCODE_RESERVED);
      classified.op         = i2cbm_pkg::op_type'(req_payload.opcode);
      classified.write_data = req_payload.write_data;
      classified.sda_in     = req_payload.sda_in;
   end

   assign req_stall = (count_ff == CNT_FULL);
   assign push      = req_valid && !req_stall;
   assign take      = pop && (count_ff != '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (take) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !take) begin
         count_in = count_ff + 1'b1;
      end else if (take && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= classified;
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.tick  = entry_ff[rd_ptr_ff];
   assign count      = count_ff;

endmodule

[hw/rtl/i2cbm_engine.sv]
// Back end of the I2C master bit engine: advances the pin sequencer by one
// tick per queued request and registers the result for the response side.
// Depends on i2cbm_pkg.
`timescale 1ns / 1ps

module i2cbm_engine (
   input  logic                 clock,
   input  logic                 reset,
   input  i2cbm_pkg::head_type  head,
   output logic                 pop,
   input  logic [15:0]          half_period,
   input  logic [7:0]           ack_timeout,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output i2cbm_pkg::rsp_type   rsp_payload
);

   localparam logic [3:0] LAST_BIT = 4'(i2cbm_pkg::BITS_PER_BYTE - 1);

   i2cbm_pkg::phase_type phase_ff, phase_in;
   logic [3:0]  bit_index_ff, bit_index_in;
   logic [7:0]  shift_ff, shift_in;
   logic [15:0] timer_ff, timer_in;
   logic [7:0]  poll_ff, poll_in;
   logic        scl_ff, scl_in;
   logic        sda_lvl_ff, sda_lvl_in;
   logic        drive_ff, drive_in;
   logic [7:0]  rx_byte_ff, rx_byte_in;
   logic        ack_err_ff, ack_err_in;
   logic        out_valid_ff;
   i2cbm_pkg::rsp_type out_ff, out_in;

   i2cbm_pkg::tick_type tick;
   logic fire;
   logic idle;
   logic start_cmd;
   logic polling;
   logic seg_run;
   logic seg_end;
   logic last_bit;
   logic timed_out;
   logic done;
   logic [7:0] rd_shift;

   assign tick      = head.tick;
   assign fire      = head.valid && (!out_valid_ff || !rsp_stall);
   assign pop       = fire;
   assign idle      = (phase_ff == i2cbm_pkg::PH_IDLE);
   assign polling   = (phase_ff == i2cbm_pkg::PH_WA_POLL);
   assign start_cmd = fire && idle && tick.cmd_go;
   assign seg_run   = fire && !idle && !polling;
   assign seg_end   = seg_run && !(timer_ff < half_period);
   assign last_bit  = (bit_index_ff >= LAST_BIT);
   assign timed_out = (poll_ff >= ack_timeout);
   assign rd_shift  = {shift_ff[6:0], tick.sda_in};
   assign done      = fire && !idle && (phase_in == i2cbm_pkg::PH_IDLE);

   // Next phase.
   always_comb begin
      phase_in = phase_ff;
      if (start_cmd) begin
         unique case (tick.op)
            i2cbm_pkg::OP_START: phase_in = i2cbm_pkg::PH_ST_A;
            i2cbm_pkg::OP_STOP:  phase_in = i2cbm_pkg::PH_SP_A;
            i2cbm_pkg::OP_WRITE: phase_in = i2cbm_pkg::PH_WR_LOW;
            i2cbm_pkg::OP_WAIT:  phase_in = i2cbm_pkg::PH_WA_RISE;
            i2cbm_pkg::OP_READ:  phase_in = i2cbm_pkg::PH_RD_LOW;
            default:             phase_in = i2cbm_pkg::PH_AK_LOW;
         endcase
      end else if (fire && polling) begin
         if (!tick.sda_in) begin
            phase_in = i2cbm_pkg::PH_WA_FALL;
         end else if (timed_out) begin
            phase_in = i2cbm_pkg::PH_IDLE;
         end
      end else if (seg_end) begin
         unique case (phase_ff)
            i2cbm_pkg::PH_ST_A:    phase_in = i2cbm_pkg::PH_ST_B;
            i2cbm_pkg::PH_ST_B:    phase_in = i2cbm_pkg::PH_ST_C;
            i2cbm_pkg::PH_SP_A:    phase_in = i2cbm_pkg::PH_SP_B;
            i2cbm_pkg::PH_SP_B:    phase_in = i2cbm_pkg::PH_SP_C;
            i2cbm_pkg::PH_WA_RISE: phase_in = i2cbm_pkg::PH_WA_POLL;
            i2cbm_pkg::PH_WR_LOW:  phase_in = i2cbm_pkg::PH_WR_HIGH;
            i2cbm_pkg::PH_WR_HIGH: phase_in = i2cbm_pkg::PH_WR_TAIL;
            i2cbm_pkg::PH_WR_TAIL: phase_in = last_bit ? i2cbm_pkg::PH_IDLE
                                                       : i2cbm_pkg::PH_WR_LOW;
            i2cbm_pkg::PH_RD_LOW:  phase_in = i2cbm_pkg::PH_RD_HIGH;
            i2cbm_pkg::PH_RD_HIGH: phase_in = last_bit ? i2cbm_pkg::PH_IDLE
                                                       : i2cbm_pkg::PH_RD_LOW;
            i2cbm_pkg::PH_AK_LOW:  phase_in = i2cbm_pkg::PH_AK_HIGH;
            default:               phase_in = i2cbm_pkg::PH_IDLE;
         endcase
      end
   end

   // Datapath and pin levels.
   always_comb begin
      bit_index_in = bit_index_ff;
      shift_in     = shift_ff;
      timer_in     = timer_ff;
      poll_in      = poll_ff;
      scl_in       = scl_ff;
      sda_lvl_in   = sda_lvl_ff;
      drive_in     = drive_ff;
      rx_byte_in   = rx_byte_ff;
      ack_err_in   = ack_err_ff;
      if (start_cmd) begin
         bit_index_in = '0;
         timer_in     = 16'd1;
         unique case (tick.op)
            i2cbm_pkg::OP_START: begin
               drive_in = 1'b1; sda_lvl_in = 1'b1; scl_in = 1'b1;
            end
            i2cbm_pkg::OP_STOP: begin
               drive_in = 1'b1; sda_lvl_in = 1'b0;
            end
            i2cbm_pkg::OP_WRITE: begin
               shift_in = tick.write_data;
               scl_in = 1'b0; drive_in = 1'b1; sda_lvl_in = tick.write_data[7];
            end
            i2cbm_pkg::OP_WAIT: begin
               drive_in = 1'b0; scl_in = 1'b1;
            end
            i2cbm_pkg::OP_READ: begin
               drive_in = 1'b0; scl_in = 1'b0; shift_in = '0;
            end
            default: begin
               scl_in = 1'b0; drive_in = 1'b1;
               sda_lvl_in = (tick.op == i2cbm_pkg::OP_NACK);
            end
         endcase
      end else if (fire && polling) begin
         if (!tick.sda_in) begin
            ack_err_in = 1'b0;
            scl_in     = 1'b0;
            timer_in   = 16'd1;
         end else if (timed_out) begin
            ack_err_in = 1'b1;
            timer_in   = '0;
         end else begin
            poll_in = poll_ff + 1'b1;
         end
      end else if (seg_run && !seg_end) begin
         timer_in = timer_ff + 1'b1;
      end else if (seg_end) begin
         timer_in = 16'd1;
         unique case (phase_ff)
            i2cbm_pkg::PH_ST_A: sda_lvl_in = 1'b0;
            i2cbm_pkg::PH_ST_B: scl_in = 1'b0;
            i2cbm_pkg::PH_SP_A: scl_in = 1'b1;
            i2cbm_pkg::PH_SP_B: sda_lvl_in = 1'b1;
            i2cbm_pkg::PH_WA_RISE: begin
               poll_in  = '0;
               timer_in = '0;
            end
            i2cbm_pkg::PH_WR_LOW:  scl_in = 1'b1;
            i2cbm_pkg::PH_WR_HIGH: scl_in = 1'b0;
            i2cbm_pkg::PH_WR_TAIL: begin
               shift_in     = {shift_ff[6:0], 1'b0};
               bit_index_in = bit_index_ff + 1'b1;
               if (!last_bit) begin
                  scl_in = 1'b0; drive_in = 1'b1; sda_lvl_in = shift_ff[6];
               end
            end
            i2cbm_pkg::PH_RD_LOW: scl_in = 1'b1;
            i2cbm_pkg::PH_RD_HIGH: begin
               shift_in     = rd_shift;
               bit_index_in = bit_index_ff + 1'b1;
               if (last_bit) begin
                  rx_byte_in = rd_shift;
               end else begin
                  scl_in = 1'b0;
               end
            end
            i2cbm_pkg::PH_AK_LOW:  scl_in = 1'b1;
            i2cbm_pkg::PH_AK_HIGH: scl_in = 1'b0;
            default: ;
         endcase
         if (phase_in == i2cbm_pkg::PH_IDLE) begin
            timer_in = '0;
         end
      end
   end

   always_comb begin
      out_in.scl_out     = scl_in;
      out_in.sda_out     = sda_lvl_in;
      out_in.sda_drive   = drive_in;
      out_in.busy_res    = (phase_in != i2cbm_pkg::PH_IDLE);
      out_in.done_res    = done;
      out_in.read_data   = rx_byte_in;
      out_in.ack_missing = ack_err_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= i2cbm_pkg::PH_IDLE;
         bit_index_ff <= '0;
         shift_ff     <= '0;
         timer_ff     <= '0;
         poll_ff      <= '0;
         scl_ff       <= 1'b1;
         sda_lvl_ff   <= 1'b1;
         drive_ff     <= 1'b1;
         rx_byte_ff   <= '0;
         ack_err_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (fire) begin
            phase_ff     <= phase_in;
            bit_index_ff <= bit_index_in;
            shift_ff     <= shift_in;
            timer_ff     <= timer_in;
            poll_ff      <= poll_in;
            scl_ff       <= scl_in;
            sda_lvl_ff   <= sda_lvl_in;
            drive_ff     <= drive_in;
            rx_byte_ff   <= rx_byte_in;
            ack_err_ff   <= ack_err_in;
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

endmodule

[verif/tb_i2c_bit_level_master.sv]
// Self-checking testbench for the I2C master bit engine: a queue-fed request driver,
// a result monitor that checks every tick against an in-bench engine model, and APB setup.
// Depends on i2cbm_pkg and i2c_bit_level_master.
`timescale 1ns / 1ps

module tb_i2c_bit_level_master;

   localparam int unsigned RANDOM_TICKS  = 1150;
   localparam int unsigned IDLE_LIMIT    = 1000;

   typedef enum int {SDA_LOW, SDA_HIGH, SDA_RANDOM} sda_pattern_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   i2cbm_pkg::req_type req_payload = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   i2cbm_pkg::rsp_type rsp_payload;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [i2cbm_pkg::CSR_ADDR_WIDTH-1:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   i2c_bit_level_master i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Engine model state and its copy of the registers.
   i2cbm_pkg::phase_type m_phase;
   logic [3:0]  m_bit;
   logic [7:0]  m_shift;
   logic [15:0] m_timer;
   logic [7:0]  m_poll;
   logic        m_scl;
   logic        m_sda;
   logic        m_drive;
   logic [7:0]  m_rdata;
   logic        m_ackerr;
   logic [15:0] cfg_half;
   logic [7:0]  cfg_timeout;

   i2cbm_pkg::req_type tick_queue[$];
   i2cbm_pkg::rsp_type pin_forecast[$];
   i2cbm_pkg::rsp_type next_result;
   int unsigned queued_ticks = 0;
   int unsigned cmds_queued = 0;
   int unsigned accepted_ticks = 0;
   int unsigned checked_ticks = 0;
   int unsigned settings_used = 0;
   int unsigned mismatches = 0;
   int unsigned idle_cycles = 0;
   logic        req_fired = 1'b0;
   int          burst_left = 0;
   int          gap_left = 0;
   int          stall_mode = 0;
   int          stall_count = 0;
   int unsigned stall_phase = 0;

   function automatic void enter_phase(input i2cbm_pkg::phase_type ph);
      m_phase = ph;
      m_timer = 16'd1;
   endfunction

   function automatic void load_write_bit();
      m_scl = 1'b0;
      m_drive = 1'b1;
      m_sda = m_shift[7];
      enter_phase(i2cbm_pkg::PH_WR_LOW);
   endfunction

   // Advances the model by one tick and returns the pin and status levels after it.
   function automatic i2cbm_pkg::rsp_type engine_tick(input i2cbm_pkg::req_type rq);
      i2cbm_pkg::rsp_type rs;
      logic    fin;
      fin = 1'b0;
      if (m_phase == i2cbm_pkg::PH_IDLE) begin
         if (rq.cmd_valid && rq.opcode != i2cbm_pkg::OPCODE_RESERVED) begin
            m_bit = 4'd0;
            case (rq.opcode)
               i2cbm_pkg::OP_START: begin
                  m_drive = 1'b1; m_sda = 1'b1; m_scl = 1'b1;
                  enter_phase(i2cbm_pkg::PH_ST_A);
               end
               i2cbm_pkg::OP_STOP: begin
                  m_drive = 1'b1; m_sda = 1'b0;
                  enter_phase(i2cbm_pkg::PH_SP_A);
               end
               i2cbm_pkg::OP_WRITE: begin
                  m_shift = rq.write_data;
                  load_write_bit();
               end
               i2cbm_pkg::OP_WAIT: begin
                  m_drive = 1'b0; m_scl = 1'b1;
                  enter_phase(i2cbm_pkg::PH_WA_RISE);
               end
               i2cbm_pkg::OP_READ: begin
                  m_drive = 1'b0; m_scl = 1'b0; m_shift = 8'h00;
                  enter_phase(i2cbm_pkg::PH_RD_LOW);
               end
               default: begin
                  m_scl = 1'b0; m_drive = 1'b1;
                  m_sda = (rq.opcode == i2cbm_pkg::OP_NACK);
                  enter_phase(i2cbm_pkg::PH_AK_LOW);
               end
            endcase
         end
      end else if (m_phase == i2cbm_pkg::PH_WA_POLL) begin
         if (rq.sda_in == 1'b0) begin
            m_ackerr = 1'b0;
            m_scl = 1'b0;
            enter_phase(i2cbm_pkg::PH_WA_FALL);
         end else if (m_poll >= cfg_timeout) begin
            // Too many high polls: give up with SCL still high.
            m_ackerr = 1'b1;
            fin = 1'b1;
         end else begin
            m_poll = m_poll + 8'd1;
         end
      end else if (m_timer < cfg_half) begin
         m_timer = m_timer + 16'd1;
      end else begin
         case (m_phase)
            i2cbm_pkg::PH_ST_A: begin m_sda = 1'b0; enter_phase(i2cbm_pkg::PH_ST_B); end
            i2cbm_pkg::PH_ST_B: begin m_scl = 1'b0; enter_phase(i2cbm_pkg::PH_ST_C); end
            i2cbm_pkg::PH_SP_A: begin m_scl = 1'b1; enter_phase(i2cbm_pkg::PH_SP_B); end
            i2cbm_pkg::PH_SP_B: begin m_sda = 1'b1; enter_phase(i2cbm_pkg::PH_SP_C); end
            i2cbm_pkg::PH_WA_RISE: begin
               m_poll = 8'd0;
               m_phase = i2cbm_pkg::PH_WA_POLL;
               m_timer = 16'd0;
            end
            i2cbm_pkg::PH_WR_LOW: begin
               m_scl = 1'b1; enter_phase(i2cbm_pkg::PH_WR_HIGH);
            end
            i2cbm_pkg::PH_WR_HIGH: begin
               m_scl = 1'b0; enter_phase(i2cbm_pkg::PH_WR_TAIL);
            end
            i2cbm_pkg::PH_WR_TAIL: begin
               m_shift = {m_shift[6:0], 1'b0};
               m_bit = m_bit + 4'd1;
               if (m_bit >= i2cbm_pkg::BITS_PER_BYTE) fin = 1'b1;
               else load_write_bit();
            end
            i2cbm_pkg::PH_RD_LOW: begin
               m_scl = 1'b1; enter_phase(i2cbm_pkg::PH_RD_HIGH);
            end
            i2cbm_pkg::PH_RD_HIGH: begin
               m_shift = {m_shift[6:0], rq.sda_in};
               m_bit = m_bit + 4'd1;
               if (m_bit >= i2cbm_pkg::BITS_PER_BYTE) begin
                  m_rdata = m_shift;
                  fin = 1'b1;
               end else begin
                  m_scl = 1'b0;
                  enter_phase(i2cbm_pkg::PH_RD_LOW);
               end
            end
            i2cbm_pkg::PH_AK_LOW: begin
               m_scl = 1'b1; enter_phase(i2cbm_pkg::PH_AK_HIGH);
            end
            i2cbm_pkg::PH_AK_HIGH: begin m_scl = 1'b0; fin = 1'b1; end
            default: fin = 1'b1;
         endcase
      end
      if (fin) begin
         m_phase = i2cbm_pkg::PH_IDLE;
         m_timer = 16'd0;
      end
      rs.scl_out = m_scl;
      rs.sda_out = m_sda;
      rs.sda_drive = m_drive;
      rs.busy_res = (m_phase != i2cbm_pkg::PH_IDLE);
      rs.done_res = fin;
      rs.read_data = m_rdata;
      rs.ack_missing = m_ackerr;
      return rs;
   endfunction

   // Request driver: bursts of back-to-back requests separated by random gaps.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fired) begin
         if (gap_left > 0) begin
            gap_left = gap_left - 1;
            req_valid <= 1'b0;
         end else if (tick_queue.size() > 0) begin
            req_payload <= tick_queue.pop_front();
            req_valid <= 1'b1;
            if (burst_left > 0) begin
               burst_left = burst_left - 1;
            end else begin
               burst_left = $urandom_range(1, 64);
               gap_left = ($urandom_range(0, 4) < 2) ? 0 : $urandom_range(1, 6);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result stall pattern: switches between free-running, light, heavy and periodic stalls.
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (stall_count == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_count = $urandom_range(20, 150);
         end else begin
            stall_count = stall_count - 1;
         end
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2: rsp_stall <= ($urandom_range(0, 2) != 0);
            default: rsp_stall <= ((stall_phase % 5) < 2);
         endcase
         stall_phase = stall_phase + 1;
      end
   end

   // Accepted requests feed the model; accepted results are checked in order.
   always @(posedge clock) begin
      if (reset) begin
         req_fired <= 1'b0;
      end else begin
         req_fired <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            pin_forecast.push_back(engine_tick(req_payload));
            accepted_ticks <= accepted_ticks + 1;
         end
         if (rsp_valid && !rsp_stall) begin
            if (pin_forecast.size() == 0) begin
               mismatches = mismatches + 1;
               $display("%0t: unexpected result %h with no request outstanding",
                        $time, rsp_payload);
            end else begin
               next_result = pin_forecast.pop_front();
               if (rsp_payload !== next_result) begin
                  mismatches = mismatches + 1;
                  $display({"%0t: tick %0d expected scl=%b sda=%b drv=%b busy=%b done=%b ",
                            "rd=%h nak=%b, got scl=%b sda=%b drv=%b busy=%b done=%b ",
                            "rd=%h nak=%b"}, $time, checked_ticks,
                           next_result.scl_out, next_result.sda_out,
                           next_result.sda_drive, next_result.busy_res,
                           next_result.done_res, next_result.read_data,
                           next_result.ack_missing, rsp_payload.scl_out,
                           rsp_payload.sda_out, rsp_payload.sda_drive,
                           rsp_payload.busy_res, rsp_payload.done_res,
                           rsp_payload.read_data, rsp_payload.ack_missing);
               end
               checked_ticks <= checked_ticks + 1;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles = idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no request or result moved for %0d cycles", $time, IDLE_LIMIT);
         $display("DONE: errors detected");
         $finish;
      end
   end

   function automatic void push_tick(input logic v, input logic [2:0] op,
                                     input logic [7:0] d, input logic s);
      i2cbm_pkg::req_type rq;
      rq.cmd_valid = v;
      rq.opcode = op;
      rq.write_data = d;
      rq.sda_in = s;
      tick_queue.push_back(rq);
      queued_ticks = queued_ticks + 1;
      if (v) cmds_queued = cmds_queued + 1;
   endfunction

   function automatic void push_fillers(input int n, input sda_pattern_type pat);
      logic [31:0] rnd;
      repeat (n) begin
         rnd = $urandom;
         push_tick(1'b0, rnd[2:0], rnd[10:3],
                   (pat == SDA_RANDOM) ? rnd[11] : (pat == SDA_HIGH));
      end
   endfunction

   // A zero half period still takes one tick per segment.
   function automatic int ticks_per_phase();
      return (cfg_half == 16'd0) ? 1 : int'(cfg_half);
   endfunction

   // Queues a command and exactly the ticks it needs to finish.
   function automatic void issue_cmd(input logic [2:0] op, input logic [7:0] d,
                                     input sda_pattern_type pat);
      int h;
      int n;
      h = ticks_per_phase();
      case (op)
         i2cbm_pkg::OP_START, i2cbm_pkg::OP_STOP: n = 3 * h;
         i2cbm_pkg::OP_WRITE:                     n = 24 * h;
         i2cbm_pkg::OP_READ:                      n = 16 * h;
         default:                                 n = 2 * h;
      endcase
      push_tick(1'b1, op, d, 1'($urandom_range(0, 1)));
      push_fillers(n, pat);
   endfunction

   function automatic void issue_wait(input logic acked, input int polls);
      logic [31:0] rnd;
      rnd = $urandom;
      push_tick(1'b1, i2cbm_pkg::OP_WAIT, rnd[7:0], rnd[8]);
      push_fillers(ticks_per_phase(), SDA_RANDOM);
      if (acked) begin
         push_fillers(polls, SDA_HIGH);
         push_fillers(1, SDA_LOW);
         push_fillers(ticks_per_phase(), SDA_RANDOM);
      end else begin
         push_fillers(int'(cfg_timeout) + 1, SDA_HIGH);
      end
   endfunction

   // A few idle ticks between commands; now and then a stray command lands in them.
   function automatic void add_slack();
      logic [31:0] rnd;
      repeat ($urandom_range(0, 3)) begin
         rnd = $urandom;
         push_tick(($urandom_range(0, 24) == 0), rnd[2:0], rnd[10:3], rnd[11]);
      end
   endfunction

   function automatic void run_transfer();
      int n;
      int limit;
      logic [31:0] rnd;
      issue_cmd(i2cbm_pkg::OP_START, 8'($urandom), SDA_RANDOM);
      add_slack();
      repeat ($urandom_range(1, 3)) begin
         issue_cmd(i2cbm_pkg::OP_WRITE, 8'($urandom), SDA_RANDOM);
         add_slack();
         limit = (cfg_timeout > 4) ? 4 : int'(cfg_timeout);
         if ($urandom_range(0, 3) == 0) limit = int'(cfg_timeout);
         issue_wait(($urandom_range(0, 4) != 0), int'($urandom_range(0, limit)));
         add_slack();
      end
      if ($urandom_range(0, 3) == 0) begin
         issue_cmd(i2cbm_pkg::OP_START, 8'($urandom), SDA_RANDOM);
         add_slack();
      end
      n = $urandom_range(0, 2);
      for (int k = 0; k < n; k++) begin
         rnd = $urandom;
         issue_cmd(i2cbm_pkg::OP_READ, rnd[7:0], SDA_RANDOM);
         add_slack();
         issue_cmd((k == n - 1) ? i2cbm_pkg::OP_NACK : i2cbm_pkg::OP_ACK, rnd[15:8],
                   SDA_RANDOM);
         add_slack();
      end
      issue_cmd(i2cbm_pkg::OP_STOP, 8'($urandom), SDA_RANDOM);
      add_slack();
   endfunction

   task automatic wait_drain();
      @(negedge clock);
      while (checked_ticks != queued_ticks) @(negedge clock);
   endtask

   // Drains the result channel, then runs idle ticks until the engine is back to idle.
   task automatic settle_engine();
      wait_drain();
      while (m_phase != i2cbm_pkg::PH_IDLE) begin
         push_fillers(32, SDA_RANDOM);
         wait_drain();
      end
      repeat (4) @(negedge clock);
   endtask

   task automatic csr_read_check(input logic idx);
      logic [31:0] got;
      @(negedge clock);
      psel = 1'b1; penable = 1'b0; pwrite = 1'b0; paddr = {idx, 2'b00};
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      got = prdata;
      @(negedge clock);
      psel = 1'b0; penable = 1'b0;
      if (idx == i2cbm_pkg::CSR_IDX_HALF_PERIOD) begin
         if (got[15:0] !== cfg_half) begin
            mismatches = mismatches + 1;
            $display("%0t: half period register expected %0d, got %0d",
                     $time, cfg_half, got[15:0]);
         end
      end else if (got[7:0] !== cfg_timeout) begin
         mismatches = mismatches + 1;
         $display("%0t: ack timeout register expected %0d, got %0d",
                  $time, cfg_timeout, got[7:0]);
      end
   endtask

   task automatic csr_write(input logic idx, input logic [31:0] val);
      @(negedge clock);
      psel = 1'b1; penable = 1'b0; pwrite = 1'b1; paddr = {idx, 2'b00}; pwdata = val;
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      if (idx == i2cbm_pkg::CSR_IDX_HALF_PERIOD) cfg_half = val[15:0];
      else cfg_timeout = val[7:0];
      @(negedge clock);
      psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
      csr_read_check(idx);
   endtask

   task automatic set_config(input int h, input int t);
      settle_engine();
      csr_write(i2cbm_pkg::CSR_IDX_HALF_PERIOD, h);
      csr_write(i2cbm_pkg::CSR_IDX_ACK_TIMEOUT, t);
      settings_used = settings_used + 1;
   endtask

   initial begin
      logic [31:0]  rnd;
      int           phase_no;
      int           h;
      int           t;
      int unsigned  phase_base;
      int unsigned  random_base;

      m_phase = i2cbm_pkg::PH_IDLE;
      m_bit = 4'd0;
      m_shift = 8'h00;
      m_timer = 16'd0;
      m_poll = 8'd0;
      m_scl = 1'b1;
      m_sda = 1'b1;
      m_drive = 1'b1;
      m_rdata = 8'h00;
      m_ackerr = 1'b0;
      cfg_half = i2cbm_pkg::HALF_PERIOD_RESET;
      cfg_timeout = i2cbm_pkg::ACK_TIMEOUT_RESET;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      csr_read_check(i2cbm_pkg::CSR_IDX_HALF_PERIOD);
      csr_read_check(i2cbm_pkg::CSR_IDX_ACK_TIMEOUT);
      // One start at the reset half period.
      issue_cmd(i2cbm_pkg::OP_START, 8'h00, SDA_RANDOM);

      set_config(1, 2);
      issue_cmd(i2cbm_pkg::OP_START, 8'h00, SDA_RANDOM);
      issue_cmd(i2cbm_pkg::OP_WRITE, 8'hFF, SDA_RANDOM);
      issue_wait(1'b1, 0);
      issue_cmd(i2cbm_pkg::OP_WRITE, 8'h00, SDA_RANDOM);
      issue_wait(1'b1, 2);
      issue_cmd(i2cbm_pkg::OP_WRITE, 8'hA5, SDA_RANDOM);
      issue_wait(1'b0, 0);
      issue_cmd(i2cbm_pkg::OP_READ, 8'h00, SDA_HIGH);
      issue_cmd(i2cbm_pkg::OP_ACK, 8'hFF, SDA_RANDOM);
      issue_cmd(i2cbm_pkg::OP_READ, 8'hFF, SDA_LOW);
      issue_cmd(i2cbm_pkg::OP_NACK, 8'h00, SDA_RANDOM);
      // A second command on the tick after a write starts is ignored.
      push_tick(1'b1, i2cbm_pkg::OP_WRITE, 8'h3C, 1'b0);
      push_tick(1'b1, i2cbm_pkg::OP_READ, 8'hC3, 1'b1);
      push_fillers(24 * ticks_per_phase() - 1, SDA_RANDOM);
      // The reserved opcode starts nothing.
      push_tick(1'b1, i2cbm_pkg::OPCODE_RESERVED, 8'hFF, 1'b1);
      push_fillers(2, SDA_RANDOM);
      issue_cmd(i2cbm_pkg::OP_STOP, 8'hFF, SDA_RANDOM);

      // Zero half period and zero ack timeout.
      set_config(0, 0);
      issue_cmd(i2cbm_pkg::OP_START, 8'h00, SDA_RANDOM);
      issue_wait(1'b0, 0);
      issue_cmd(i2cbm_pkg::OP_STOP, 8'h00, SDA_RANDOM);

      random_base = queued_ticks;
      phase_no = 0;
      while (queued_ticks - random_base < RANDOM_TICKS) begin
         case (phase_no)
            0: begin h = 1; t = 3; end
            1: begin h = 2; t = 0; end
            2: begin h = 1; t = 255; end
            3: begin h = 0; t = 1; end
            4: begin h = 3; t = 8; end
            default: begin
               h = $urandom_range(1, 4);
               t = ($urandom_range(0, 5) == 0) ? 255 : $urandom_range(0, 8);
            end
         endcase
         set_config(h, t);
         phase_base = queued_ticks;
         while (queued_ticks - phase_base < 220) begin
            if ($urandom_range(0, 9) == 0) begin
               repeat ($urandom_range(5, 20)) begin
                  rnd = $urandom;
                  push_tick(rnd[12], rnd[2:0], rnd[10:3], rnd[11]);
               end
            end else begin
               run_transfer();
            end
         end
         phase_no = phase_no + 1;
      end

      // Widest half period, written and read back only.
      set_config(65535, 255);
      settle_engine();

      if (pin_forecast.size() != 0) begin
         mismatches = mismatches + 1;
         $display("%0t: %0d expected results never arrived", $time, pin_forecast.size());
      end
      $display("Sent %0d ticks and checked %0d carrying %0d commands over %0d settings,",
               accepted_ticks, checked_ticks, cmds_queued, settings_used);
      $display("from zero to widest half period and zero to longest ack timeout.");
      if (mismatches == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
